// ===== rtl/mmss_led_matrix_pixel_render_defines.svh =====
// assertion helpers for the mm:ss pixel renderer
// both sample on clock and are disabled while reset is high
`ifndef MMSS_LED_MATRIX_PIXEL_RENDER_DEFINES_SVH
`define MMSS_LED_MATRIX_PIXEL_RENDER_DEFINES_SVH

// condition in the same cycle
`define MMSS_ASSERT_SAME(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("mmss render check failed");

// condition in the following cycle
`define MMSS_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("mmss render check failed");

`endif

// ===== rtl/mmss_pkg.sv =====
`timescale 1ns / 1ps

package mmss_pkg;

   localparam logic [7:0] RED_LEVEL_RESET = 8'd40;

   localparam logic [3:0] GLYPH_TOP      = 4'd4;
   localparam logic [3:0] GLYPH_BOTTOM   = 4'd11;
   localparam logic [3:0] MIN_TENS_COL   = 4'd0;
   localparam logic [3:0] MIN_ONES_COL   = 4'd4;
   localparam logic [3:0] COLON_COL      = 4'd7;
   localparam logic [3:0] SEC_TENS_COL   = 4'd9;
   localparam logic [3:0] SEC_ONES_COL   = 4'd13;
   localparam logic [2:0] COLON_UPPER    = 3'd2;
   localparam logic [2:0] COLON_LOWER    = 3'd5;

   // reciprocals: t/60 = (t*69906)>>22 for 16-bit t, m/10 = (m*3277)>>15 for m < 2048
   localparam logic [16:0] RECIP_SIXTY   = 17'd69906;
   localparam logic [11:0] RECIP_TEN     = 12'd3277;

   typedef struct packed {
      logic [15:0] time_seconds;
      logic [7:0]  strip_index;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_color;
      logic        pixel_lit;
   } rsp_type;

   typedef struct packed {
      logic [15:0] time_seconds;
      logic [10:0] minutes;
      logic [3:0]  row;
      logic [3:0]  col;
   } split_type;

   typedef struct packed {
      logic [10:0] minutes;
      logic [6:0]  min_tens;
      logic [5:0]  seconds;
      logic [3:0]  row;
      logic [3:0]  col;
   } digit_type;

   // 3x8 font, row 0 in the top bits, glyph column 0 is the msb of each row
   function automatic logic [23:0] glyph_word(logic [6:0] digit);
      logic [23:0] word;
      case (digit)
         7'd0: word = {3'd0, 3'd7, 3'd5, 3'd5, 3'd5, 3'd5, 3'd7, 3'd0};
         7'd1: word = {3'd0, 3'd2, 3'd6, 3'd2, 3'd2, 3'd2, 3'd7, 3'd0};
         7'd2: word = {3'd0, 3'd7, 3'd1, 3'd3, 3'd6, 3'd4, 3'd7, 3'd0};
         7'd3: word = {3'd0, 3'd7, 3'd1, 3'd2, 3'd1, 3'd1, 3'd7, 3'd0};
         7'd4: word = {3'd0, 3'd5, 3'd5, 3'd7, 3'd1, 3'd1, 3'd1, 3'd0};
         7'd5: word = {3'd0, 3'd7, 3'd4, 3'd7, 3'd1, 3'd1, 3'd7, 3'd0};
         7'd6: word = {3'd0, 3'd3, 3'd4, 3'd7, 3'd5, 3'd5, 3'd7, 3'd0};
         7'd7: word = {3'd0, 3'd7, 3'd1, 3'd2, 3'd2, 3'd4, 3'd4, 3'd0};
         7'd8: word = {3'd0, 3'd7, 3'd5, 3'd7, 3'd5, 3'd5, 3'd7, 3'd0};
         7'd9: word = {3'd0, 3'd7, 3'd5, 3'd5, 3'd7, 3'd1, 3'd6, 3'd0};
         // anything above nine is blank
         default: word = 24'd0;
      endcase
      return word;
   endfunction

   function automatic logic glyph_on(logic [6:0] digit, logic [2:0] grow, logic [1:0] gcol);
      logic [23:0] word;
      logic [4:0]  bit_sel;
      word    = glyph_word(digit);
      bit_sel = 5'd23 - 5'({grow, 1'b0} + {2'b00, grow}) - {3'b000, gcol};
      return (gcol <= 2'd2) && word[bit_sel];
   endfunction

endpackage

// ===== rtl/mmss_time_split.sv =====
`timescale 1ns / 1ps

module mmss_time_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  mmss_pkg::req_type   in_req,
   output logic                out_valid,
   output mmss_pkg::split_type out_split
);

   logic                valid_ff;
   logic                valid_in;
   mmss_pkg::split_type split_ff;
   mmss_pkg::split_type split_in;
   logic [32:0]         product;

   always_comb begin
      product  = {17'd0, in_req.time_seconds} * {16'd0, mmss_pkg::RECIP_SIXTY};
      valid_in = in_valid;
      split_in.time_seconds = in_req.time_seconds;
      split_in.minutes      = product[32:22];
      split_in.row          = in_req.strip_index[7:4];
      // even rows run backwards, odd rows forwards
      split_in.col          = in_req.strip_index[4] ? in_req.strip_index[3:0]
                                                    : ~in_req.strip_index[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      split_ff <= split_in;
   end

   assign out_valid = valid_ff;
   assign out_split = split_ff;

endmodule

// ===== rtl/mmss_digit_split.sv =====
`timescale 1ns / 1ps

module mmss_digit_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  mmss_pkg::split_type in_split,
   output logic                out_valid,
   output mmss_pkg::digit_type out_digit
);

   logic                valid_ff;
   logic                valid_in;
   mmss_pkg::digit_type digit_ff;
   mmss_pkg::digit_type digit_in;
   logic [16:0]         minutes_x60;
   logic [16:0]         seconds_full;
   logic [22:0]         tens_product;

   always_comb begin
      minutes_x60  = {in_split.minutes, 6'd0} - {4'd0, in_split.minutes, 2'd0};
      seconds_full = {1'b0, in_split.time_seconds} - minutes_x60;
      tens_product = {12'd0, in_split.minutes} * {11'd0, mmss_pkg::RECIP_TEN};
      valid_in           = in_valid;
      digit_in.minutes   = in_split.minutes;
      digit_in.min_tens  = tens_product[21:15];
      digit_in.seconds   = seconds_full[5:0];
      digit_in.row       = in_split.row;
      digit_in.col       = in_split.col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      digit_ff <= digit_in;
   end

   assign out_valid = valid_ff;
   assign out_digit = digit_ff;

endmodule

// ===== rtl/mmss_pixel_lookup.sv =====
`timescale 1ns / 1ps

module mmss_pixel_lookup (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  mmss_pkg::digit_type in_digit,
   input  logic [7:0]          red_level,
   output logic                out_valid,
   output mmss_pkg::rsp_type   out_rsp
);

   logic              valid_ff;
   logic              valid_in;
   mmss_pkg::rsp_type rsp_ff;
   mmss_pkg::rsp_type rsp_in;
   logic [10:0]       min_tens_x10;
   logic [3:0]        min_ones;
   logic [9:0]        sec_product;
   logic [2:0]        sec_tens;
   logic [5:0]        sec_tens_x10;
   logic [3:0]        sec_ones;
   logic [2:0]        grow;
   logic              lit;

   always_comb begin
      min_tens_x10 = 11'({in_digit.min_tens, 3'd0}) + 11'({in_digit.min_tens, 1'b0});
      min_ones     = 4'(in_digit.minutes - min_tens_x10);
      // s/10 = (s*13)>>7 for s < 64
      sec_product  = {1'b0, in_digit.seconds, 3'd0} + {2'd0, in_digit.seconds, 2'd0}
                   + {4'd0, in_digit.seconds};
      sec_tens     = sec_product[9:7];
      sec_tens_x10 = 6'({sec_tens, 3'd0}) + 6'({sec_tens, 1'b0});
      sec_ones     = 4'(in_digit.seconds - sec_tens_x10);
      grow         = 3'(in_digit.row - mmss_pkg::GLYPH_TOP);
      lit          = 1'b0;

      if (in_digit.row inside {[mmss_pkg::GLYPH_TOP:mmss_pkg::GLYPH_BOTTOM]}) begin
         case (in_digit.col) inside
            [4'd0:4'd2]: begin
               lit = mmss_pkg::glyph_on(in_digit.min_tens, grow,
                                        2'(in_digit.col - mmss_pkg::MIN_TENS_COL));
            end
            [4'd4:4'd6]: begin
               lit = mmss_pkg::glyph_on({3'd0, min_ones}, grow,
                                        2'(in_digit.col - mmss_pkg::MIN_ONES_COL));
            end
            mmss_pkg::COLON_COL: begin
               lit = (grow == mmss_pkg::COLON_UPPER) || (grow == mmss_pkg::COLON_LOWER);
            end
            [4'd9:4'd11]: begin
               lit = mmss_pkg::glyph_on({4'd0, sec_tens}, grow,
                                        2'(in_digit.col - mmss_pkg::SEC_TENS_COL));
            end
            [4'd13:4'd15]: begin
               lit = mmss_pkg::glyph_on({3'd0, sec_ones}, grow,
                                        2'(in_digit.col - mmss_pkg::SEC_ONES_COL));
            end
            // gap columns
            default: begin
               lit = 1'b0;
            end
         endcase
      end

      valid_in           = in_valid;
      rsp_in.pixel_lit   = lit;
      rsp_in.pixel_color = lit ? {red_level, 16'd0} : 24'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ===== rtl/mmss_led_matrix_pixel_render.sv =====
// a request accepted passes the time split, digit split and pixel lookup registers before its result strobe
// throughput: one request per cycle, busy is never raised; three registered stages
// (minutes split, digit split, font lookup), the receiver cannot stall
// reset: synchronous active high, empties the pipeline and sets red level to 40
`timescale 1ns / 1ps
`include "mmss_led_matrix_pixel_render_defines.svh"

module mmss_led_matrix_pixel_render (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mmss_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mmss_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data
);

   logic [7:0]          red_level_ff;
   logic [7:0]          red_level_in;
   logic                accept;
   logic                split_valid;
   mmss_pkg::split_type split_data;
   logic                digit_valid;
   mmss_pkg::digit_type digit_data;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign red_level_in = csr_write_enable ? csr_write_data : red_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_level_ff <= mmss_pkg::RED_LEVEL_RESET;
      end else begin
         red_level_ff <= red_level_in;
      end
   end

   mmss_time_split u_time_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .out_valid (split_valid),
      .out_split (split_data)
   );

   mmss_digit_split u_digit_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_split  (split_data),
      .out_valid (digit_valid),
      .out_digit (digit_data)
   );

   mmss_pixel_lookup u_pixel_lookup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (digit_valid),
      .in_digit  (digit_data),
      .red_level (red_level_ff),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

   // every request comes out of the pipeline as a result strobe, and nothing else does
   `MMSS_ASSERT_NEXT(a_latency, accept, ##2 rsp_strobe)
   `MMSS_ASSERT_SAME(a_no_phantom, rsp_strobe, $past(accept, 3))
   `MMSS_ASSERT_SAME(a_dark_zero, rsp_strobe && !rsp_data.pixel_lit, rsp_data.pixel_color == 24'd0)
   `MMSS_ASSERT_SAME(a_lit_red, rsp_strobe && rsp_data.pixel_lit, rsp_data.pixel_color == {$past(red_level_ff), 16'd0})

endmodule
